// File: src/indexed_deque_list_assert.svh
// Assertion macros for the list block. Define NO_ASSERTIONS to drop them.
`ifndef INDEXED_DEQUE_LIST_ASSERT_SVH
`define INDEXED_DEQUE_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define IDL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IDL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IDL_ASSERT(label, clk, rst, prop, msg)
`define IDL_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: src/idl_pkg.sv
package idl_pkg;

   localparam int CAPACITY  = 64;
   // widest cell index the command struct can carry (CAPACITY up to 1024)
   localparam int IdxMaxW   = 10;
   localparam int PosW      = 8;
   localparam int ValW      = 32;
   localparam int CountOutW = 7;

   typedef enum logic [3:0] {
      ACT_PUSH_FRONT = 4'd0,
      ACT_PUSH_BACK  = 4'd1,
      ACT_INSERT_AT  = 4'd2,
      ACT_POP_FRONT  = 4'd3,
      ACT_POP_BACK   = 4'd4,
      ACT_REMOVE_AT  = 4'd5,
      ACT_FIND_NEXT  = 4'd6,
      ACT_FIND_PREV  = 4'd7,
      ACT_CLEAR      = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NONEIGH  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_INS  = 2'd1,
      CELL_DEL  = 2'd2
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type              op;
      logic [IdxMaxW-1:0]       at;
      logic                     find;
      logic signed [ValW-1:0]   value;
   } cell_cmd_type;

endpackage

// File: src/idl_if.sv
interface idl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [3:0]                           action;
   logic [idl_pkg::PosW-1:0]             position;
   logic signed [idl_pkg::ValW-1:0]      item_value;

   modport source (output valid, action, position, item_value, input ready);
   modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface idl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           status;
   logic signed [idl_pkg::ValW-1:0]      neighbour_value;
   logic [idl_pkg::CountOutW-1:0]        element_count;

   modport source (output valid, status, neighbour_value, element_count, input ready);
   modport sink   (input valid, status, neighbour_value, element_count, output ready);
endinterface

// File: src/idl_cell.sv
module idl_cell #(
   parameter int Index = 0
) (
   input  logic                            clock,
   input  idl_pkg::cell_cmd_type           cmd,
   input  logic signed [idl_pkg::ValW-1:0] left_value,
   input  logic signed [idl_pkg::ValW-1:0] right_value,
   output logic signed [idl_pkg::ValW-1:0] value,
   output logic                            match
);

   localparam logic [idl_pkg::IdxMaxW-1:0] MyIdx = idl_pkg::IdxMaxW'(Index);

   logic signed [idl_pkg::ValW-1:0] value_ff, value_in;
   logic                            match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         idl_pkg::CELL_INS: begin
            if (MyIdx == cmd.at) begin
               value_in = cmd.value;
            end else if (MyIdx > cmd.at) begin
               value_in = left_value;
            end
         end
         idl_pkg::CELL_DEL: begin
            if (MyIdx >= cmd.at) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   // compare against the old contents; a find never moves data
   assign match_in = cmd.find ? (value_ff == cmd.value) : match_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

// File: src/idl_pick.sv
module idl_pick #(
   parameter int Capacity = idl_pkg::CAPACITY,
   parameter int CountW   = $clog2(idl_pkg::CAPACITY + 1)
) (
   input  logic [Capacity-1:0]                     match,
   input  logic [Capacity-1:0][idl_pkg::ValW-1:0]  values,
   input  logic [CountW-1:0]                       count,
   input  logic                                    prev,
   output idl_pkg::status_type                     status,
   output logic signed [idl_pkg::ValW-1:0]         neighbour
);

   logic [Capacity-1:0]      held;
   logic [Capacity-1:0]      hit;
   logic [Capacity-1:0]      first;
   logic [Capacity-1:0]      sel;
   logic [idl_pkg::ValW-1:0] picked;

   always_comb begin
      for (int k = 0; k < Capacity; k++) begin
         held[k] = CountW'(k) < count;
      end
   end

   // isolate the lowest set bit: first match from the head
   assign hit   = match & held;
   assign first = hit & (~hit + Capacity'(1));
   assign sel   = prev ? (first >> 1) : (first << 1);

   always_comb begin
      picked = '0;
      for (int k = 0; k < Capacity; k++) begin
         picked = picked | ({idl_pkg::ValW{sel[k] & held[k]}} & values[k]);
      end
   end

   always_comb begin
      status    = idl_pkg::ST_OK;
      neighbour = '0;
      if (hit == '0) begin
         status = idl_pkg::ST_NOTFOUND;
      end else if ((sel & held) == '0) begin
         status = idl_pkg::ST_NONEIGH;
      end else begin
         neighbour = picked;
      end
   end

endmodule

// File: src/indexed_deque_list.sv
// Channel  Dir  Fields                                      Moves when
// req_if   in   action, position, item_value                valid && ready
// rsp_if   out  status, neighbour_value, element_count      valid && ready
//
// Each item passes the cell chain and then the result register: the chain
// shifts or compares on the accept edge, then the first match is picked and
// the result register loaded once it is free. A new item is taken once the
// result is in that register. A result held by a stalled rsp_if keeps the
// following item from loading it. Reset empties the list; no clearing pass.
`include "indexed_deque_list_assert.svh"

module indexed_deque_list #(
   parameter int Capacity = idl_pkg::CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   idl_req_if.sink      req_if,
   idl_rsp_if.source    rsp_if
);

   localparam int CountW  = $clog2(Capacity + 1);
   localparam int CmpW    = (CountW > idl_pkg::PosW) ? CountW : idl_pkg::PosW;
   localparam int CntExtW = (CountW > idl_pkg::CountOutW) ? CountW : idl_pkg::CountOutW;

   logic [CountW-1:0]               count_ff, count_in;
   logic                            busy_ff;
   idl_pkg::status_type             b_status_ff, b_status_in;
   logic                            b_find_ff;
   logic                            b_prev_ff, b_prev_in;
   logic                            rsp_valid_ff;
   idl_pkg::status_type             rsp_status_ff;
   logic signed [idl_pkg::ValW-1:0] rsp_neighbour_ff;
   logic [idl_pkg::CountOutW-1:0]   rsp_count_ff;

   idl_pkg::action_type             act;
   idl_pkg::cell_op_type            op;
   logic [idl_pkg::IdxMaxW-1:0]     at;
   logic                            find;
   idl_pkg::cell_cmd_type           cmd;
   logic [CmpW-1:0]                 pos_ext, cnt_ext;
   logic                            full, empty, accept, out_free;

   logic [Capacity-1:0][idl_pkg::ValW-1:0] values;
   logic [Capacity-1:0]                    match;
   idl_pkg::status_type                    pick_status;
   logic signed [idl_pkg::ValW-1:0]        pick_neighbour;
   logic [CntExtW-1:0]                     cnt_wide;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !busy_ff;
   assign act           = idl_pkg::action_type'(req_if.action);
   assign pos_ext       = CmpW'(req_if.position);
   assign cnt_ext       = CmpW'(count_ff);
   assign full          = count_ff == CountW'(Capacity);
   assign empty         = count_ff == '0;

   always_comb begin
      op          = idl_pkg::CELL_HOLD;
      at          = '0;
      find        = 1'b0;
      b_prev_in   = 1'b0;
      b_status_in = idl_pkg::ST_OK;
      count_in    = count_ff;
      unique case (act) inside
         idl_pkg::ACT_PUSH_FRONT, idl_pkg::ACT_PUSH_BACK, idl_pkg::ACT_INSERT_AT: begin
            if (full) begin
               b_status_in = idl_pkg::ST_FULL;
            end else begin
               op       = idl_pkg::CELL_INS;
               count_in = count_ff + 1'b1;
               if (act == idl_pkg::ACT_PUSH_FRONT
                   || (act == idl_pkg::ACT_INSERT_AT && pos_ext == '0)) begin
                  at = '0;
               end else if (act == idl_pkg::ACT_PUSH_BACK || pos_ext >= cnt_ext) begin
                  at = idl_pkg::IdxMaxW'(cnt_ext);
               end else begin
                  at = idl_pkg::IdxMaxW'(pos_ext);
               end
            end
         end
         idl_pkg::ACT_POP_FRONT, idl_pkg::ACT_POP_BACK, idl_pkg::ACT_REMOVE_AT: begin
            if (empty) begin
               b_status_in = idl_pkg::ST_EMPTY;
            end else begin
               op       = idl_pkg::CELL_DEL;
               count_in = count_ff - 1'b1;
               if (act == idl_pkg::ACT_POP_FRONT
                   || (act == idl_pkg::ACT_REMOVE_AT && pos_ext == '0)) begin
                  at = '0;
               end else if (act == idl_pkg::ACT_POP_BACK
                            || pos_ext >= cnt_ext - 1'b1) begin
                  at = idl_pkg::IdxMaxW'(cnt_ext - 1'b1);
               end else begin
                  at = idl_pkg::IdxMaxW'(pos_ext);
               end
            end
         end
         idl_pkg::ACT_FIND_NEXT, idl_pkg::ACT_FIND_PREV: begin
            find      = 1'b1;
            b_prev_in = act == idl_pkg::ACT_FIND_PREV;
         end
         idl_pkg::ACT_CLEAR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   assign cmd.op    = accept ? op : idl_pkg::CELL_HOLD;
   assign cmd.at    = at;
   assign cmd.find  = accept && find;
   assign cmd.value = req_if.item_value;

   for (genvar k = 0; k < Capacity; k++) begin : g_cell
      logic signed [idl_pkg::ValW-1:0] left_v, right_v;
      if (k == 0) begin : g_head
         assign left_v = values[k];
      end else begin : g_body
         assign left_v = values[k-1];
      end
      if (k == Capacity - 1) begin : g_tail
         assign right_v = values[k];
      end else begin : g_link
         assign right_v = values[k+1];
      end
      idl_cell #(.Index(k)) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (values[k]),
         .match       (match[k])
      );
   end

   idl_pick #(.Capacity(Capacity), .CountW(CountW)) u_pick (
      .match     (match),
      .values    (values),
      .count     (count_ff),
      .prev      (b_prev_ff),
      .status    (pick_status),
      .neighbour (pick_neighbour)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign cnt_wide = CntExtW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            busy_ff  <= 1'b1;
         end else if (busy_ff && out_free) begin
            busy_ff <= 1'b0;
         end
         if (busy_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_status_ff <= b_status_in;
         b_find_ff   <= find;
         b_prev_ff   <= b_prev_in;
      end
      if (busy_ff && out_free) begin
         rsp_status_ff    <= b_find_ff ? pick_status : b_status_ff;
         rsp_neighbour_ff <= b_find_ff ? pick_neighbour : '0;
         rsp_count_ff     <= cnt_wide[idl_pkg::CountOutW-1:0];
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.neighbour_value = rsp_neighbour_ff;
   assign rsp_if.element_count   = rsp_count_ff;

   `IDL_ASSERT(a_count_bound, clock, reset, count_ff <= CountW'(Capacity), "count beyond capacity")
   `IDL_ASSERT(a_busy_drains, clock, reset, busy_ff && !rsp_valid_ff |=> rsp_valid_ff && !busy_ff, "item stuck")
   `IDL_ASSERT(a_full_holds, clock, reset, accept && b_status_in == idl_pkg::ST_FULL |=> $stable(count_ff), "full add changed count")
   `IDL_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy_ff && !rsp_valid_ff, "not idle after reset")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int WatchdogLimit = 2000;
   localparam int MaxPrinted    = 40;

   typedef struct {
      idl_pkg::status_type                status;
      logic signed [idl_pkg::ValW-1:0]    neighbour;
      logic [idl_pkg::CountOutW-1:0]      count;
   } list_result_type;

   logic clock = 1'b0;
   logic reset;

   idl_req_if req ();
   idl_rsp_if rsp ();

   indexed_deque_list dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   // predicted list contents, head at index 0
   logic signed [idl_pkg::ValW-1:0] list_model[$];
   list_result_type                 pending_results[$];

   int mismatches      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int full_hits       = 0;
   int empty_hits      = 0;
   int notfound_hits   = 0;
   int noneigh_hits    = 0;
   bit idling_on       = 1'b1;
   int hold_cycles     = 0;
   int stall_left      = 0;
   int idle_cycles     = 0;

   always #2 clock = ~clock;

   function automatic list_result_type apply_action(logic [3:0] act,
                                                    logic [idl_pkg::PosW-1:0] pos,
                                                    logic signed [idl_pkg::ValW-1:0] value);
      list_result_type res;
      int count;
      int hit;
      int k;
      res.status    = idl_pkg::ST_OK;
      res.neighbour = '0;
      count         = list_model.size();
      hit           = count;
      for (k = 0; k < count; k++)
         if (hit == count && list_model[k] == value) hit = k;
      case (act)
         idl_pkg::ACT_PUSH_FRONT, idl_pkg::ACT_PUSH_BACK, idl_pkg::ACT_INSERT_AT: begin
            if (count >= idl_pkg::CAPACITY) res.status = idl_pkg::ST_FULL;
            else if (act == idl_pkg::ACT_PUSH_FRONT
                     || (act == idl_pkg::ACT_INSERT_AT && pos == 0))
               list_model.push_front(value);
            else if (act == idl_pkg::ACT_PUSH_BACK || pos >= count)
               list_model.push_back(value);
            else list_model.insert(int'(pos), value);
         end
         idl_pkg::ACT_POP_FRONT, idl_pkg::ACT_POP_BACK, idl_pkg::ACT_REMOVE_AT: begin
            if (count == 0) res.status = idl_pkg::ST_EMPTY;
            else if (act == idl_pkg::ACT_POP_FRONT
                     || (act == idl_pkg::ACT_REMOVE_AT && pos == 0))
               void'(list_model.pop_front());
            else if (act == idl_pkg::ACT_POP_BACK || pos >= count - 1)
               void'(list_model.pop_back());
            else list_model.delete(int'(pos));
         end
         idl_pkg::ACT_FIND_NEXT: begin
            if (hit >= count) res.status = idl_pkg::ST_NOTFOUND;
            else if (hit + 1 >= count) res.status = idl_pkg::ST_NONEIGH;
            else res.neighbour = list_model[hit + 1];
         end
         idl_pkg::ACT_FIND_PREV: begin
            if (hit >= count) res.status = idl_pkg::ST_NOTFOUND;
            else if (hit == 0) res.status = idl_pkg::ST_NONEIGH;
            else res.neighbour = list_model[hit - 1];
         end
         idl_pkg::ACT_CLEAR: list_model.delete();
         default: ;   // unused codes leave the list alone
      endcase
      case (res.status)
         idl_pkg::ST_FULL:     full_hits++;
         idl_pkg::ST_EMPTY:    empty_hits++;
         idl_pkg::ST_NOTFOUND: notfound_hits++;
         idl_pkg::ST_NONEIGH:  noneigh_hits++;
         default: ;
      endcase
      res.count = idl_pkg::CountOutW'(list_model.size());
      return res;
   endfunction

   task automatic report_mismatch(string field_name, longint got, longint want);
      mismatches++;
      if (mismatches <= MaxPrinted)
         $display("%0t: mismatch on %s of result %0d: got %0d, expected %0d",
                  $time, field_name, results_checked, got, want);
   endtask

   task automatic check_result();
      list_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("status (no item outstanding)", rsp.status, -1);
         return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
      if (rsp.neighbour_value !== want.neighbour)
         report_mismatch("neighbour_value", rsp.neighbour_value, want.neighbour);
      if (rsp.element_count !== want.count)
         report_mismatch("element_count", rsp.element_count, want.count);
   endtask

   // result side: check, then pick next ready (long hold, stall burst or ready)
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) check_result();
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_action(logic [3:0] act, logic [idl_pkg::PosW-1:0] pos,
                              logic signed [idl_pkg::ValW-1:0] value);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.action     <= act;
      req.position   <= pos;
      req.item_value <= value;
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(apply_action(act, pos, value));
      items_sent++;
   endtask

   task automatic wait_all_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // searches mostly hit held values or a small pool so duplicates are common
   task automatic random_item(int add_pct, int remove_pct);
      logic [3:0]                      act;
      logic [idl_pkg::PosW-1:0]        pos;
      logic signed [idl_pkg::ValW-1:0] value;
      int roll;
      int size;
      size = list_model.size();
      roll = $urandom_range(0, 199);
      if (roll == 0) act = idl_pkg::ACT_CLEAR;
      else if (roll < 5) act = 4'($urandom_range(9, 15));
      else begin
         roll = $urandom_range(0, 99);
         if (roll < add_pct)
            act = 4'($urandom_range(idl_pkg::ACT_PUSH_FRONT, idl_pkg::ACT_INSERT_AT));
         else if (roll < add_pct + remove_pct)
            act = 4'($urandom_range(idl_pkg::ACT_POP_FRONT, idl_pkg::ACT_REMOVE_AT));
         else act = $urandom_range(0, 1) ? idl_pkg::ACT_FIND_NEXT : idl_pkg::ACT_FIND_PREV;
      end
      if ($urandom_range(0, 3) == 0) pos = idl_pkg::PosW'($urandom);
      else pos = idl_pkg::PosW'($urandom_range(0, size + 1));
      if (size != 0 && $urandom_range(0, 2) != 0) value = list_model[$urandom_range(0, size - 1)];
      else if ($urandom_range(0, 1)) value = $urandom_range(0, 15) - 8;
      else value = $urandom;
      send_action(act, pos, value);
   endtask

   task automatic test_directed();
      send_action(idl_pkg::ACT_POP_FRONT, 0, 0);
      send_action(idl_pkg::ACT_POP_BACK, 0, 0);
      send_action(idl_pkg::ACT_REMOVE_AT, 8'hFF, 0);
      send_action(idl_pkg::ACT_FIND_NEXT, 0, 0);
      send_action(idl_pkg::ACT_FIND_PREV, 0, 0);
      send_action(idl_pkg::ACT_PUSH_FRONT, 0, 32'sh8000_0000);
      send_action(idl_pkg::ACT_PUSH_BACK, 0, 32'sh7FFF_FFFF);
      send_action(idl_pkg::ACT_INSERT_AT, 0, -1);
      send_action(idl_pkg::ACT_INSERT_AT, 3, 0);               // exactly at the count
      send_action(idl_pkg::ACT_INSERT_AT, 2, 5);
      send_action(idl_pkg::ACT_INSERT_AT, 8'hFF, 5);           // far past the end, duplicate
      send_action(idl_pkg::ACT_PUSH_BACK, 8'hAA, 7);
      send_action(idl_pkg::ACT_FIND_NEXT, 0, 5);               // first match wins
      send_action(idl_pkg::ACT_FIND_PREV, 0, 5);
      send_action(idl_pkg::ACT_FIND_NEXT, 0, 7);               // tail has no next
      send_action(idl_pkg::ACT_FIND_PREV, 0, -1);              // head has no previous
      send_action(idl_pkg::ACT_FIND_NEXT, 0, 1234);
      send_action(4'd9, 8'hFF, -1);
      send_action(4'd15, 8'h55, 32'sh5555_5555);
      send_action(idl_pkg::ACT_REMOVE_AT, 0, 0);
      send_action(idl_pkg::ACT_REMOVE_AT, 1, 0);
      send_action(idl_pkg::ACT_REMOVE_AT, 3, 0);               // one before the tail
      send_action(idl_pkg::ACT_REMOVE_AT, 200, 0);
      send_action(idl_pkg::ACT_CLEAR, 0, 0);
      send_action(idl_pkg::ACT_POP_BACK, 0, 0);
      wait_all_results();
   endtask

   task automatic test_fill_to_capacity();
      int k;
      for (k = 0; k < idl_pkg::CAPACITY + 4; k++)
         send_action(4'($urandom_range(idl_pkg::ACT_PUSH_FRONT, idl_pkg::ACT_INSERT_AT)),
                     idl_pkg::PosW'($urandom), idl_pkg::ValW'($urandom_range(0, 20)));
      for (k = 0; k < 8; k++)
         send_action((k % 2) ? idl_pkg::ACT_FIND_PREV : idl_pkg::ACT_FIND_NEXT, 0,
                     list_model[$urandom_range(0, list_model.size() - 1)]);
      for (k = 0; k < idl_pkg::CAPACITY + 2; k++)
         send_action(4'($urandom_range(idl_pkg::ACT_POP_FRONT, idl_pkg::ACT_REMOVE_AT)),
                     idl_pkg::PosW'($urandom_range(0, idl_pkg::CAPACITY)),
                     idl_pkg::ValW'($urandom));
      wait_all_results();
   endtask

   // receiver holds off while items keep coming, so the input must stall
   task automatic test_backpressure();
      int k;
      hold_cycles = 80;
      for (k = 0; k < 16; k++) random_item(40, 30);
      wait_all_results();
   endtask

   task automatic test_random_mix();
      int phase;
      int k;
      for (phase = 0; phase < 5; phase++) begin
         idling_on = (phase != 2);
         for (k = 0; k < 100; k++) begin
            case (phase % 3)
               0: random_item(55, 15);
               1: random_item(15, 55);
               default: random_item(35, 35);
            endcase
         end
         wait_all_results();
      end
      idling_on = 1'b1;
   endtask

   task automatic test_streaming();
      int k;
      idling_on = 1'b0;
      for (k = 0; k < 60; k++) random_item(35, 35);
      wait_all_results();
   endtask

   initial begin
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.action     <= '0;
      req.position   <= '0;
      req.item_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_to_capacity();
      test_backpressure();
      test_random_mix();
      test_streaming();

      repeat (10) @(posedge clock);
      $display("Covered %0d items, %0d results checked; %0d adds into a full list,",
               items_sent, results_checked, full_hits);
      $display("%0d removals from an empty list, %0d failed and %0d neighbourless lookups.",
               empty_hits, notfound_hits, noneigh_hits);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
